[rtl/core/dpp_pkg.sv]
package dpp_pkg;

  // Default widths of the depth sample and of the pixel indices.
  localparam int unsigned DPP_DEPTH_BITS = 16;
  localparam int unsigned DPP_COORD_BITS = 12;

  // Configuration port.
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = CFG_IDX_W'(3);

  localparam logic [CFG_W-1:0] FOCAL_X_RST  = 16'd9600;
  localparam logic [CFG_W-1:0] FOCAL_Y_RST  = 16'd9600;
  localparam logic [CFG_W-1:0] CENTER_X_RST = 16'd5120;
  localparam logic [CFG_W-1:0] CENTER_Y_RST = 16'd3840;

  // Result widths and saturation limits.
  localparam int unsigned FWD_W   = 20;
  localparam int unsigned COORD_W = 32;

  localparam logic [FWD_W-1:0]   FWD_MAX = 20'hF_FFFF;
  localparam logic [COORD_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] NEG_MIN = 32'h8000_0000;

  // Divider geometry: 32 quotient bits, two per pipeline step.
  localparam int unsigned QUO_W         = 32;
  localparam int unsigned DVS_W         = CFG_W + 1;
  localparam int unsigned BITS_PER_STEP = 2;
  localparam int unsigned DIV_STEPS     = QUO_W / BITS_PER_STEP;

  // One coordinate lane as it passes through the divider stages.
  typedef struct packed {
    logic [DVS_W-1:0] rem;   // partial remainder, below dvs unless ovf is set
    logic [QUO_W-1:0] low;   // dividend bits not yet brought down
    logic [QUO_W-1:0] quo;   // quotient bits produced so far
    logic [DVS_W-1:0] dvs;   // divisor, twice the focal length
    logic             ovf;   // quotient does not fit in 32 bits
    logic             zero;  // product of difference and depth is zero
    logic             neg;   // result takes the negative sign
  } lane_t;

  // Per-item data that travels alongside the two lanes.
  typedef struct packed {
    logic             pt_valid;
    logic [FWD_W-1:0] fwd;
  } meta_t;

  // Two restoring division steps.
  function automatic lane_t div_step(lane_t a);
    lane_t          r;
    logic [DVS_W:0] t;
    r = a;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      t     = {r.rem, r.low[QUO_W-1]};
      r.low = {r.low[QUO_W-2:0], 1'b0};
      if (t >= {1'b0, r.dvs}) begin
        r.rem = DVS_W'(t - {1'b0, r.dvs});
        r.quo = {r.quo[QUO_W-2:0], 1'b1};
      end else begin
        r.rem = t[DVS_W-1:0];
        r.quo = {r.quo[QUO_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Applies the sign and saturates the rounded magnitude to 32 bits.
  function automatic logic [COORD_W-1:0] lane_result(lane_t a);
    logic [COORD_W-1:0] res;
    if (a.zero) begin
      res = '0;
    end else if (a.neg) begin
      if (a.ovf || (a.quo > NEG_MIN)) begin
        res = NEG_MIN;
      end else begin
        res = COORD_W'(-a.quo);
      end
    end else if (a.ovf || a.quo[QUO_W-1]) begin
      res = POS_MAX;
    end else begin
      res = a.quo;
    end
    return res;
  endfunction

endpackage

[rtl/core/depth_pixel_to_point_top.sv]
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    depth_mm_i, column_i, row_i
// out       output     out_valid_o / out_ready_i  point_valid_o, forward_mm_o,
//                                                 lateral_mm_o, vertical_mm_o
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Each pixel passes through 20 register stages, and one pixel can enter every cycle while
// the output is not stalled. Most stages belong to the rounding divider, which produces two
// quotient bits in each of its 16 stages; three front stages and the output register make
// up the rest. Reset clears every stage's valid bit and loads the default camera intrinsics.
// When the output is stalled, each stage holds only while the stage after it is full, so
// empty slots in the pipeline still take new pixels.
module depth_pixel_to_point_top #(
  parameter int unsigned DEPTH_BITS = dpp_pkg::DPP_DEPTH_BITS,
  parameter int unsigned COORD_BITS = dpp_pkg::DPP_COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Pixel input
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [DEPTH_BITS-1:0]        depth_mm_i,
  input  logic [COORD_BITS-1:0]        column_i,
  input  logic [COORD_BITS-1:0]        row_i,
  // Point output
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         point_valid_o,
  output logic [dpp_pkg::FWD_W-1:0]    forward_mm_o,
  output logic signed [dpp_pkg::COORD_W-1:0] lateral_mm_o,
  output logic signed [dpp_pkg::COORD_W-1:0] vertical_mm_o,
  // Configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dpp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dpp_pkg::CFG_W-1:0]    cfg_data_i
);
  import dpp_pkg::*;

  // Q.4 pixel position and its difference from the principal point.
  localparam int unsigned PW     = COORD_BITS + 4;
  localparam int unsigned DIFF_W = (PW > CFG_W) ? PW : CFG_W;
  // Product of difference and depth; the rounded numerator 2*16*prod + focal
  // needs five more bits and one for the carry.
  localparam int unsigned PROD_W = DIFF_W + DEPTH_BITS;
  localparam int unsigned NUM_W  = PROD_W + 6;
  localparam int unsigned NW     = (NUM_W > QUO_W + DVS_W) ? NUM_W : QUO_W + DVS_W;
  localparam int unsigned TOP_W  = NW - QUO_W;
  localparam int unsigned FEXT_W = (DEPTH_BITS + 4 > FWD_W) ? DEPTH_BITS + 4 : FWD_W;
  // Stage 0 forms differences, stage 1 multiplies, stage 2 sets up the
  // division, stages 3 to DIV_STEPS+2 divide and the last stage saturates.
  localparam int unsigned NS     = DIV_STEPS + 4;
  localparam int unsigned LANES  = 2;

  // Configuration registers. The port is always ready; an unknown index
  // leaves every register unchanged.
  logic [CFG_W-1:0] focal_x_q, focal_y_q, center_x_q, center_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= FOCAL_X_RST;
      focal_y_q  <= FOCAL_Y_RST;
      center_x_q <= CENTER_X_RST;
      center_y_q <= CENTER_Y_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FOCAL_X:  focal_x_q  <= cfg_data_i;
        REG_FOCAL_Y:  focal_y_q  <= cfg_data_i;
        REG_CENTER_X: center_x_q <= cfg_data_i;
        REG_CENTER_Y: center_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Lane 0 is the lateral coordinate (column), lane 1 the vertical (row).
  logic [COORD_BITS-1:0] coord   [LANES];
  logic [CFG_W-1:0]      center  [LANES];
  logic [CFG_W-1:0]      focal   [LANES];

  assign coord[0]  = column_i;
  assign coord[1]  = row_i;
  assign center[0] = center_x_q;
  assign center[1] = center_y_q;
  assign focal[0]  = focal_x_q;
  assign focal[1]  = focal_y_q;

  // Stage advance chain: a stage may load when it is empty or when the
  // stage after it is taking its contents.
  logic [NS-1:0] vld_q;
  logic [NS-1:0] adv;

  assign adv[NS-1] = ~vld_q[NS-1] | out_ready_i;
  for (genvar s = 0; s < NS - 1; s++) begin : g_adv
    assign adv[s] = ~vld_q[s] | adv[s+1];
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NS; s++) begin
        if (adv[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  // Stage 0 inputs: magnitude of (position - centre) and the result sign,
  // which is negative when the pixel lies at or beyond the centre.
  logic [DIFF_W-1:0] pos_e  [LANES];
  logic [DIFF_W-1:0] cen_e  [LANES];
  logic [DIFF_W-1:0] diff_d [LANES];
  logic              neg_d  [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      pos_e[l] = DIFF_W'({coord[l], 4'b0000});
      cen_e[l] = DIFF_W'(center[l]);
      neg_d[l] = (pos_e[l] >= cen_e[l]);
      if (neg_d[l]) begin
        diff_d[l] = pos_e[l] - cen_e[l];
      end else begin
        diff_d[l] = cen_e[l] - pos_e[l];
      end
    end
  end

  // Forward distance is the depth in Q.4, clipped to the 20-bit field.
  logic [FEXT_W-1:0] fwd_ext;
  meta_t             meta_d;

  always_comb begin
    fwd_ext         = FEXT_W'({depth_mm_i, 4'b0000});
    meta_d.pt_valid = |depth_mm_i;
    if (fwd_ext > FEXT_W'(FWD_MAX)) begin
      meta_d.fwd = FWD_MAX;
    end else begin
      meta_d.fwd = fwd_ext[FWD_W-1:0];
    end
  end

  // Stage 2 inputs: numerator 2*num + focal against divisor 2*focal. The
  // quotient overflows 32 bits exactly when the bits above the low 32 are
  // not below the divisor; a zero focal length always lands there.
  logic [NW-1:0]    num_d [LANES];
  logic [TOP_W-1:0] top_d [LANES];
  lane_t            setup_d [LANES];

  // Pipeline payload registers.
  logic [DEPTH_BITS-1:0] depth1_q;
  logic [DIFF_W-1:0]     diff1_q [LANES];
  logic                  neg1_q  [LANES];
  logic [PROD_W-1:0]     prod2_q [LANES];
  logic                  neg2_q  [LANES];
  lane_t                 lane_q  [LANES][DIV_STEPS+1];
  meta_t                 meta_q  [NS-1];
  logic                  pt_valid_q;
  logic [FWD_W-1:0]      fwd_q;
  logic [COORD_W-1:0]    coord_q [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num_d[l]         = NW'({prod2_q[l], 5'b00000}) + NW'(focal[l]);
      top_d[l]         = num_d[l][NW-1:QUO_W];
      setup_d[l].dvs   = {focal[l], 1'b0};
      setup_d[l].ovf   = (top_d[l] >= TOP_W'(setup_d[l].dvs));
      setup_d[l].zero  = (prod2_q[l] == '0);
      setup_d[l].neg   = neg2_q[l];
      setup_d[l].rem   = top_d[l][DVS_W-1:0];
      setup_d[l].low   = num_d[l][QUO_W-1:0];
      setup_d[l].quo   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      depth1_q  <= depth_mm_i;
      meta_q[0] <= meta_d;
      for (int l = 0; l < LANES; l++) begin
        diff1_q[l] <= diff_d[l];
        neg1_q[l]  <= neg_d[l];
      end
    end
    if (adv[1]) begin
      meta_q[1] <= meta_q[0];
      for (int l = 0; l < LANES; l++) begin
        prod2_q[l] <= PROD_W'(diff1_q[l]) * PROD_W'(depth1_q);
        neg2_q[l]  <= neg1_q[l];
      end
    end
    if (adv[2]) begin
      meta_q[2] <= meta_q[1];
      for (int l = 0; l < LANES; l++) begin
        lane_q[l][0] <= setup_d[l];
      end
    end
    for (int k = 1; k <= DIV_STEPS; k++) begin
      if (adv[k+2]) begin
        meta_q[k+2] <= meta_q[k+1];
        for (int l = 0; l < LANES; l++) begin
          lane_q[l][k] <= div_step(lane_q[l][k-1]);
        end
      end
    end
    if (adv[NS-1]) begin
      pt_valid_q <= meta_q[NS-2].pt_valid;
      fwd_q      <= meta_q[NS-2].fwd;
      for (int l = 0; l < LANES; l++) begin
        coord_q[l] <= lane_result(lane_q[l][DIV_STEPS]);
      end
    end
  end

  assign point_valid_o = pt_valid_q;
  assign forward_mm_o  = fwd_q;
  assign lateral_mm_o  = $signed(coord_q[0]);
  assign vertical_mm_o = $signed(coord_q[1]);

endmodule

[tb/sv/testbench.sv]
module testbench;
  import dpp_pkg::*;

  // Widths of the pixel fields at the block's default parameters.
  localparam int unsigned DW = DPP_DEPTH_BITS;
  localparam int unsigned CW = DPP_COORD_BITS;

  // One back-projected point as it should leave the block.
  typedef struct {
    logic                      ok;
    logic [FWD_W-1:0]          fwd;
    logic signed [COORD_W-1:0] lat;
    logic signed [COORD_W-1:0] vert;
  } point_t;

  // Keeps its own copy of the camera intrinsics, works out the point for
  // every pixel the block takes in, and compares the points that come out
  // against those expectations in order.
  class point_projector;
    logic [CFG_W-1:0] focal_x, focal_y, center_x, center_y;
    point_t           expected_points[$];
    int               faults;

    function new();
      focal_x  = FOCAL_X_RST;
      focal_y  = FOCAL_Y_RST;
      center_x = CENTER_X_RST;
      center_y = CENTER_Y_RST;
      faults   = 0;
    endfunction

    // Writes to an index outside the register map are dropped by the block.
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_FOCAL_X:  focal_x  = v;
        REG_FOCAL_Y:  focal_y  = v;
        REG_CENTER_X: center_x = v;
        REG_CENTER_Y: center_y = v;
        default: ;
      endcase
    endfunction

    // -(pix*16 - ctr) * depth * 16 / foc, rounded half away from zero and
    // saturated to 32 bits. A zero focal length saturates towards the sign.
    function logic signed [COORD_W-1:0] project_axis(logic [CW-1:0] pix,
        logic [CFG_W-1:0] ctr, logic [CFG_W-1:0] foc, logic [DW-1:0] depth);
      longint unsigned           pos, diff, num, mag, fden;
      bit                        neg;
      logic signed [COORD_W-1:0] res;
      pos = pix;
      pos = pos << 4;
      if (pos >= ctr) begin
        diff = pos - ctr;
        neg  = 1'b1;
      end else begin
        diff = ctr - pos;
        neg  = 1'b0;
      end
      num = diff * depth * 16;
      if (num == 0) return '0;
      fden = foc;
      if (fden == 0) begin
        mag = NEG_MIN;
        mag = mag + 1;
      end else begin
        mag = (2 * num + fden) / (2 * fden);
      end
      if (neg) begin
        if (mag > NEG_MIN) mag = NEG_MIN;
        res = mag[COORD_W-1:0];
        return -res;
      end
      if (mag > POS_MAX) mag = POS_MAX;
      res = mag[COORD_W-1:0];
      return res;
    endfunction

    function void note_pixel(logic [DW-1:0] d, logic [CW-1:0] c, logic [CW-1:0] r);
      point_t p;
      if (d == '0) begin
        p.ok   = 1'b0;
        p.fwd  = '0;
        p.lat  = '0;
        p.vert = '0;
      end else begin
        p.ok   = 1'b1;
        p.fwd  = {d, 4'h0};
        p.lat  = project_axis(c, center_x, focal_x, d);
        p.vert = project_axis(r, center_y, focal_y, d);
      end
      expected_points.push_back(p);
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (expected_points.size() == 0) begin
        $error("point arrived with none expected: valid %0b fwd %0d lat %0d vert %0d",
               got.ok, got.fwd, got.lat, got.vert);
        faults++;
        return;
      end
      want = expected_points.pop_front();
      if (got.ok !== want.ok) begin
        $error("point_valid: expected %0b, got %0b", want.ok, got.ok);
        faults++;
      end
      if (got.fwd !== want.fwd) begin
        $error("forward_mm: expected %0d, got %0d", want.fwd, got.fwd);
        faults++;
      end
      if (got.lat !== want.lat) begin
        $error("lateral_mm: expected %0d, got %0d", want.lat, got.lat);
        faults++;
      end
      if (got.vert !== want.vert) begin
        $error("vertical_mm: expected %0d, got %0d", want.vert, got.vert);
        faults++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [DW-1:0]             depth_mm_i;
  logic [CW-1:0]             column_i;
  logic [CW-1:0]             row_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic                      point_valid_o;
  logic [FWD_W-1:0]          forward_mm_o;
  logic signed [COORD_W-1:0] lateral_mm_o;
  logic signed [COORD_W-1:0] vertical_mm_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i;
  logic [CFG_W-1:0]          cfg_data_i;

  depth_pixel_to_point_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .depth_mm_i    (depth_mm_i),
    .column_i      (column_i),
    .row_i         (row_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .point_valid_o (point_valid_o),
    .forward_mm_o  (forward_mm_o),
    .lateral_mm_o  (lateral_mm_o),
    .vertical_mm_o (vertical_mm_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  point_projector projector = new();

  // Percentages of cycles in which the pixel source and the point sink hold
  // back. They follow the number of pixels sent so far.
  int tx_idle_pct = 30;
  int rx_idle_pct = 63;
  int pixels_sent = 0;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // The sink decides at each falling edge whether it will take a point at
  // the next rising edge.
  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Every point transfer is checked at the rising edge on which it happens.
  // Outputs are read before the block's registers update in that time step.
  always @(posedge clk_i) begin
    point_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.ok   = point_valid_o;
      got.fwd  = forward_mm_o;
      got.lat  = lateral_mm_o;
      got.vert = vertical_mm_o;
      projector.check_point(got);
    end
  end

  // Offers one pixel, possibly after a short gap, and returns once the
  // transfer has taken place. Valid is left high so that a following pixel
  // can go out on the very next cycle; the caller lowers it when no pixel
  // follows.
  task automatic send_pixel(logic [DW-1:0] d, logic [CW-1:0] c, logic [CW-1:0] r);
    int gap;
    // The first third of the run stalls the sink hardest, the second third
    // the source, and the last third runs at full rate on both sides.
    if (pixels_sent < 450) begin
      tx_idle_pct = 30;
      rx_idle_pct = 63;
    end else if (pixels_sent < 900) begin
      tx_idle_pct = 63;
      rx_idle_pct = 30;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    // Each cycle is left idle with the chosen percentage.
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    depth_mm_i = d;
    column_i   = c;
    row_i      = r;
    do @(posedge clk_i); while (!in_ready_o);
    projector.note_pixel(d, c, r);
    pixels_sent++;
  endtask

  // Stops the pixel stream and waits until every expected point has been
  // seen, which leaves the block idle.
  task automatic drain_points();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (projector.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    projector.set_reg(idx, v);
  endtask

  // Loads a full set of intrinsics, followed by a write to an unmapped index
  // that the block must ignore.
  task automatic load_camera(logic [CFG_W-1:0] fx, logic [CFG_W-1:0] fy,
                             logic [CFG_W-1:0] cx, logic [CFG_W-1:0] cy);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(CFG_IDX_W'(REG_CENTER_Y + 1 + $urandom_range(0, 11)),
              CFG_W'($urandom_range(0, 65535)));
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Random pixels. Depths lean towards zero, the top of the range and
  // small values; coordinates sometimes sit on the edges of the sensor or
  // right next to the principal point, where the results pass through zero.
  task automatic stream_pixels(int count, bit pause_midway);
    logic [DW-1:0] d;
    logic [CW-1:0] c, r;
    int            sel;
    for (int k = 0; k < count; k++) begin
      if (pause_midway && k == count / 2) drain_points();
      sel = $urandom_range(0, 9);
      case (sel)
        0:       d = '0;
        1:       d = '1;
        2:       d = DW'($urandom_range(1, 15));
        default: d = DW'($urandom_range(0, 65535));
      endcase
      sel = $urandom_range(0, 7);
      case (sel)
        0: begin
          c = '0;
          r = '1;
        end
        1: begin
          c = '1;
          r = '0;
        end
        2: begin
          c = CW'((projector.center_x >> 4) + $urandom_range(0, 2) - 1);
          r = CW'((projector.center_y >> 4) + $urandom_range(0, 2) - 1);
        end
        default: begin
          c = CW'($urandom_range(0, 4095));
          r = CW'($urandom_range(0, 4095));
        end
      endcase
      send_pixel(d, c, r);
    end
  endtask

  // A hang anywhere in the run ends it here, far beyond any correct run.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    depth_mm_i  = '0;
    column_i    = '0;
    row_i       = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Default intrinsics: the principal point falls on column 320, row 240.
    // A zero depth must give an invalid, all-zero point whatever the pixel.
    send_pixel('0, '0, '0);
    send_pixel('0, '1, '1);
    send_pixel(DW'(1), '0, '0);
    send_pixel('1, '0, '0);
    send_pixel('1, '1, '1);
    send_pixel('1, CW'(320), CW'(240));
    send_pixel(DW'(1), CW'(320), CW'(240));
    send_pixel(DW'(1000), CW'(321), CW'(239));
    send_pixel('1, '0, '1);
    send_pixel('1, '1, '0);
    send_pixel(DW'(1), '1, '0);
    send_pixel(DW'('hAAAA), CW'('hAAA), CW'('h555));
    send_pixel(DW'('h5555), CW'('h555), CW'('hAAA));

    // Short focal lengths: full depth at the far column saturates to the
    // most negative value, and an odd principal row gives exact halves that
    // must round away from zero in both directions.
    drain_points();
    load_camera(16'd16, 16'd32, 16'd0, 16'd1);
    send_pixel('1, '1, '0);
    send_pixel(DW'(1), '0, '0);
    send_pixel(DW'(1), '0, CW'(1));
    send_pixel('1, '0, '1);

    // Zero focal lengths: each coordinate saturates towards its sign, and
    // stays zero on the principal point itself.
    drain_points();
    load_camera('0, '0, CENTER_X_RST, CENTER_Y_RST);
    send_pixel(DW'(1), CW'(320), CW'(240));
    send_pixel(DW'(1), '0, '0);
    send_pixel(DW'(1), '1, '1);
    send_pixel('0, '0, '0);

    // Random phases, each under its own set of intrinsics and each entered
    // with the block drained.
    drain_points();
    load_camera(CFG_W'($urandom_range(16, 65535)), CFG_W'($urandom_range(16, 65535)),
                CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)));
    stream_pixels(225, 1'b0);
    drain_points();
    load_camera('1, '1, '1, '1);
    stream_pixels(225, 1'b0);
    drain_points();
    load_camera(16'd16, 16'd16, '0, '0);
    stream_pixels(225, 1'b1);
    drain_points();
    load_camera(16'd32, 16'd48, CFG_W'($urandom_range(0, 32767) * 2 + 1),
                CFG_W'($urandom_range(0, 65535)));
    stream_pixels(225, 1'b0);
    drain_points();
    load_camera(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
                CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)));
    stream_pixels(225, 1'b0);
    drain_points();
    load_camera(FOCAL_X_RST, FOCAL_Y_RST, CENTER_X_RST, CENTER_Y_RST);
    stream_pixels(225, 1'b0);

    // Let the pipeline settle well past its latency so that any stray point
    // would still be caught by the checker.
    drain_points();
    repeat (40) @(posedge clk_i);
    if (projector.faults == 0 && projector.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[depth_pixel_to_point_top.f]
rtl/core/dpp_pkg.sv
rtl/core/depth_pixel_to_point_top.sv
tb/sv/testbench.sv
